/* hw/rtl/vca_pkg.sv */
// vca_pkg: shared types and codes of the virtual channel allocator
// table entry layout, item kinds, result status codes, row search result
// no dependencies
`default_nettype none

package vca_pkg;

  // one table entry: {blocked count, owner id}
  localparam int ID_W      = 16;
  localparam int BLK_W     = 8;
  localparam int ENTRY_W   = BLK_W + ID_W;
  // channel index width for the largest supported channel count
  localparam int CH_IDX_W  = 4;

  localparam logic [1:0] KIND_RESERVE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;
  localparam logic [1:0] KIND_SETBLK  = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_FREE      = 3'd1;
  localparam logic [2:0] ST_BAD_ID       = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd4;

  // result of searching one port row
  typedef struct packed {
    logic                free_hit;
    logic [CH_IDX_W-1:0] free_ch;
    logic                id_hit;
    logic [CH_IDX_W-1:0] id_ch;
  } vca_search_t;

endpackage

`default_nettype wire

/* hw/rtl/vca_row_search.sv */
// vca_row_search: priority search over the channels of one port row
// finds the lowest free unblocked channel and the lowest owned id match
// depends on vca_pkg
`default_nettype none

module vca_row_search
  import vca_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic [CHANNEL_COUNT*ENTRY_W-1:0] row_data,
  input  logic [CHANNEL_COUNT-1:0]         owned,
  input  logic                             blk_valid,
  input  logic [ID_W-1:0]                  key_id,
  output vca_search_t                      result
);

  logic [ID_W-1:0]  ent_id;
  logic [BLK_W-1:0] ent_blk;

  // walk from the top so the lowest channel wins
  always_comb begin
    result  = '0;
    ent_id  = '0;
    ent_blk = '0;
    for (int j = CHANNEL_COUNT - 1; j >= 0; j--) begin
      ent_id  = row_data[j*ENTRY_W +: ID_W];
      ent_blk = blk_valid ? row_data[j*ENTRY_W + ID_W +: BLK_W] : '0;
      if (!owned[j] && (ent_blk == '0)) begin
        result.free_hit = 1'b1;
        result.free_ch  = CH_IDX_W'(j);
      end
      if (owned[j] && (ent_id == key_id)) begin
        result.id_hit = 1'b1;
        result.id_ch  = CH_IDX_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/virtual_channel_allocator.sv */
// virtual_channel_allocator: per-port virtual channel ownership table
// top level: item sequencer, row memory, config register, output register
// depends on vca_pkg and vca_row_search
//
// usage
//   input channel (in_*): one beat is one request: reserve, release,
//   lookup by packet id or set blocked count. in_ready is high while the
//   sequencer is idle.
//   result channel (out_*): exactly one beat per request, in order.
//   config port: APB-style, one register (invalid packet id) at address 0,
//   write only while no request is outstanding. pready is tied high.
// timing
//   reserve, release and set-blocked go from accept to the next accept
//   through row read, row modify/write back and result hand-off.
//   lookup reads the port rows one at a time through the single row memory
//   port, a row read and a modify step per row, up to the hit or the last row.
//   result is valid the cycle after the sequencer hands it off.
// reset
//   rst_n is synchronous. ownership bits, loads and peaks clear at once;
//   per-row valid bits make blocked counts read as zero, no clearing pass.
// stalls
//   the output register holds a finished result while out_ready is low and
//   the next request is still accepted; its result waits in the sequencer.
`default_nettype none

module virtual_channel_allocator
  import vca_pkg::*;
#(
  parameter int PORT_COUNT    = 4,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_port,
  input  logic [1:0]  in_channel,
  input  logic [15:0] in_packet_id,
  input  logic [7:0]  in_blocked_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_port_out,
  output logic [1:0]  out_channel_out,
  output logic [2:0]  out_load,
  output logic [2:0]  out_peak
);

  // row address, port compare, channel index and load widths
  localparam int AW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PCW   = $clog2(PORT_COUNT + 1);
  localparam int PXW   = (PCW > 2) ? PCW : 2;
  localparam int CW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CCW   = $clog2(CHANNEL_COUNT + 1);
  localparam int CXW   = (CCW > 2) ? CCW : 2;
  localparam int LW    = CCW;
  localparam int LXW   = (LW > 3) ? LW : 3;
  localparam int SXW   = (AW > 2) ? AW : 2;
  localparam int ROW_W = CHANNEL_COUNT * ENTRY_W;

  localparam logic [0:0] ADDR_INVALID_ID = 1'b0;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         kind_r;
  logic [1:0]         port_r;
  logic [1:0]         chan_r;
  logic [ID_W-1:0]    id_r;
  logic [BLK_W-1:0]   bval_r;
  logic [AW-1:0]      scan_r;
  logic [ID_W-1:0]    invalid_id_r;

  // table state held in flops: ownership, row valid, per-port counters
  logic [CHANNEL_COUNT-1:0] owned_r [PORT_COUNT];
  logic [PORT_COUNT-1:0]    row_valid_r;
  logic [LW-1:0]            load_r [PORT_COUNT];
  logic [LW-1:0]            peak_r [PORT_COUNT];

  // row memory: one row per port, {blocked, id} per channel
  logic [ROW_W-1:0] row_mem [PORT_COUNT];
  logic [ROW_W-1:0] rd_row_r;

  // finished result waiting for the output register
  logic [2:0] res_status_r, res_status_nxt;
  logic [1:0] res_port_r, res_port_nxt;
  logic [1:0] res_chan_r, res_chan_nxt;
  logic [2:0] res_load_r, res_load_nxt;
  logic [2:0] res_peak_r, res_peak_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [1:0] out_port_r;
  logic [1:0] out_chan_r;
  logic [2:0] out_load_r;
  logic [2:0] out_peak_r;

  logic                 in_fire;
  logic                 cfg_wr;
  logic                 out_free;
  logic [PXW-1:0]       port_x;
  logic [CXW-1:0]       chan_x;
  logic [SXW-1:0]       scan_x;
  logic                 port_ok;
  logic                 chan_ok;
  logic [AW-1:0]        port_row;
  logic [CW-1:0]        chan_idx;
  logic                 is_lookup;
  logic [AW-1:0]        row_sel;
  logic [AW-1:0]        ld_idx;
  logic                 found;
  logic                 ld_ok;
  logic [LW-1:0]        load_cur;
  logic [LW-1:0]        peak_cur;
  logic [ROW_W-1:0]     base_row;
  vca_search_t          srch;

  // modify stage controls
  logic                     exec;
  logic                     mem_we;
  logic                     tbl_upd;
  logic                     scan_step;
  logic [CW-1:0]            wr_ch;
  logic                     wr_set_id;
  logic                     wr_set_blk;
  logic [BLK_W-1:0]         wr_blk;
  logic [ROW_W-1:0]         wr_row;
  logic [CHANNEL_COUNT-1:0] owned_row_nxt;
  logic [LW-1:0]            load_new;
  logic [LW-1:0]            peak_new;
  logic [2:0]               st;
  logic [1:0]               ch_res;
  logic [1:0]               pout;
  logic [LXW-1:0]           load_x;
  logic [LXW-1:0]           peak_x;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == ADDR_INVALID_ID) ? {16'h0, invalid_id_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_id_r <= 16'hFFFF;
    end else if (cfg_wr && (paddr == ADDR_INVALID_ID)) begin
      invalid_id_r <= pwdata[ID_W-1:0];
    end
  end

  // handshakes
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // request decode; out-of-range ports and channels map to index zero
  assign port_x    = PXW'(port_r);
  assign chan_x    = CXW'(chan_r);
  assign scan_x    = SXW'(scan_r);
  assign port_ok   = (port_x < PXW'(PORT_COUNT));
  assign chan_ok   = (chan_x < CXW'(CHANNEL_COUNT));
  assign port_row  = port_ok ? port_x[AW-1:0] : '0;
  assign chan_idx  = chan_ok ? chan_x[CW-1:0] : '0;
  assign is_lookup = (kind_r == KIND_LOOKUP);
  assign row_sel   = is_lookup ? scan_r : port_row;

  // registered row read; write back from the modify stage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[port_row] <= wr_row;
    end
    if (state_r == S_READ) begin
      rd_row_r <= row_mem[row_sel];
    end
  end

  // blocked counts of a row never written read as zero
  always_comb begin
    base_row = rd_row_r;
    for (int j = 0; j < CHANNEL_COUNT; j++) begin
      if (!row_valid_r[row_sel]) begin
        base_row[j*ENTRY_W + ID_W +: BLK_W] = '0;
      end
    end
  end

  vca_row_search #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_search (
    .row_data (base_row),
    .owned    (owned_r[row_sel]),
    .blk_valid(1'b1),
    .key_id   (id_r),
    .result   (srch)
  );

  // load and peak reported: found port on a lookup hit, else the request port (zero if out of range)
  assign exec     = (state_r == S_EXEC);
  assign found    = is_lookup && srch.id_hit;
  assign ld_idx   = found ? scan_r : port_row;
  assign ld_ok    = found || port_ok;
  assign load_cur = load_r[ld_idx];
  assign peak_cur = peak_r[ld_idx];

  // modify stage
  always_comb begin
    mem_we        = 1'b0;
    tbl_upd       = 1'b0;
    scan_step     = 1'b0;
    wr_ch         = '0;
    wr_set_id     = 1'b0;
    wr_set_blk    = 1'b0;
    wr_blk        = '0;
    owned_row_nxt = owned_r[row_sel];
    load_new      = load_cur;
    peak_new      = peak_cur;
    st            = ST_OK;
    ch_res        = chan_r;
    pout          = port_r;
    unique case (kind_r)
      KIND_RESERVE: begin
        if (id_r == invalid_id_r) begin
          st = ST_BAD_ID;
        end else if (port_ok && srch.free_hit) begin
          ch_res     = srch.free_ch[1:0];
          wr_ch      = srch.free_ch[CW-1:0];
          wr_set_id  = 1'b1;
          mem_we     = exec;
          tbl_upd    = exec;
          owned_row_nxt[srch.free_ch[CW-1:0]] = 1'b1;
          load_new   = load_cur + LW'(1);
          peak_new   = (load_new > peak_cur) ? load_new : peak_cur;
        end else begin
          st = ST_NO_FREE;
        end
      end
      KIND_RELEASE: begin
        if (port_ok && chan_ok && owned_r[row_sel][chan_idx]) begin
          wr_ch      = chan_idx;
          wr_set_blk = 1'b1;
          mem_we     = exec;
          tbl_upd    = exec;
          owned_row_nxt[chan_idx] = 1'b0;
          load_new   = load_cur - LW'(1);
        end else begin
          st = ST_ALREADY_FREE;
        end
      end
      KIND_LOOKUP: begin
        if (srch.id_hit) begin
          pout   = scan_x[1:0];
          ch_res = srch.id_ch[1:0];
        end else if (scan_r == AW'(PORT_COUNT - 1)) begin
          st = ST_NOT_FOUND;
        end else begin
          scan_step = 1'b1;
        end
      end
      KIND_SETBLK: begin
        if (port_ok && chan_ok) begin
          wr_ch      = chan_idx;
          wr_set_blk = 1'b1;
          wr_blk     = bval_r;
          mem_we     = exec;
        end
      end
    endcase

    wr_row = base_row;
    for (int j = 0; j < CHANNEL_COUNT; j++) begin
      if (wr_ch == CW'(j)) begin
        if (wr_set_id) begin
          wr_row[j*ENTRY_W +: ID_W] = id_r;
        end
        if (wr_set_blk) begin
          wr_row[j*ENTRY_W + ID_W +: BLK_W] = wr_blk;
        end
      end
    end
  end

  // result fields; counts wider than three bits report their low bits
  assign load_x         = ld_ok ? LXW'(load_new) : '0;
  assign peak_x         = ld_ok ? LXW'(peak_new) : '0;
  assign res_status_nxt = st;
  assign res_port_nxt   = pout;
  assign res_chan_nxt   = (st == ST_OK) ? ch_res : 2'd0;
  assign res_load_nxt   = load_x[2:0];
  assign res_peak_nxt   = peak_x[2:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = scan_step ? S_READ : S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and lookup row counter
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      port_r <= in_port;
      chan_r <= in_channel;
      id_r   <= in_packet_id;
      bval_r <= in_blocked_value;
      scan_r <= '0;
    end else if (exec && scan_step) begin
      scan_r <= scan_r + AW'(1);
    end
  end

  // table flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        owned_r[i] <= '0;
        load_r[i]  <= '0;
        peak_r[i]  <= '0;
      end
    end else begin
      if (mem_we) begin
        row_valid_r[port_row] <= 1'b1;
      end
      if (tbl_upd) begin
        owned_r[port_row] <= owned_row_nxt;
        load_r[port_row]  <= load_new;
        peak_r[port_row]  <= peak_new;
      end
    end
  end

  // finished result
  always_ff @(posedge clk) begin
    if (exec && !scan_step) begin
      res_status_r <= res_status_nxt;
      res_port_r   <= res_port_nxt;
      res_chan_r   <= res_chan_nxt;
      res_load_r   <= res_load_nxt;
      res_peak_r   <= res_peak_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_status_r <= res_status_r;
      out_port_r   <= res_port_r;
      out_chan_r   <= res_chan_r;
      out_load_r   <= res_load_r;
      out_peak_r   <= res_peak_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_port_out    = out_port_r;
  assign out_channel_out = out_chan_r;
  assign out_load        = out_load_r;
  assign out_peak        = out_peak_r;

  // load of a row matches its ownership bits
  a_load_matches_owned: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> ($countones(owned_r[row_sel]) == int'(load_r[row_sel])))
    else $error("port load out of step with ownership bits");

  // peak never below the current load
  a_peak_ge_load: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> (peak_r[row_sel] >= load_r[row_sel]))
    else $error("port peak below current load");

  // an accepted beat always starts with a row read
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ))
    else $error("accepted beat did not start a row read");

  // a new result appears only from the hand-off state
  a_out_from_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result shown without hand-off");

  // a lookup never writes the table
  a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_lookup) |-> (!mem_we && !tbl_upd))
    else $error("lookup modified the table");

endmodule

`default_nettype wire
